[src/dop_pkg.sv]
// Shared types and constants for the DHCP options-area parser.
// Used by the parser core, the result register, the top level and the checker.
`default_nettype none

package dop_pkg;

    localparam int DataW = 8;
    localparam int WordW = 32;

    // Result status codes
    localparam logic [1:0] StatusEnd     = 2'd0;
    localparam logic [1:0] StatusBadMagic = 2'd1;
    localparam logic [1:0] StatusNoEnd   = 2'd2;

    // Kept lease state codes
    localparam logic [1:0] LeaseNone  = 2'd0;
    localparam logic [1:0] LeaseOffer = 2'd1;
    localparam logic [1:0] LeaseAck   = 2'd2;
    localparam logic [1:0] LeaseNak   = 2'd3;

    // Parser phase codes
    localparam logic [2:0] PhIdle  = 3'd0;
    localparam logic [2:0] PhMagic = 3'd1;
    localparam logic [2:0] PhCode  = 3'd2;
    localparam logic [2:0] PhLen   = 3'd3;
    localparam logic [2:0] PhData  = 3'd4;

    // Option codes
    localparam logic [7:0] OptPad    = 8'd0;
    localparam logic [7:0] OptSubnet = 8'd1;
    localparam logic [7:0] OptLease  = 8'd51;
    localparam logic [7:0] OptType   = 8'd53;
    localparam logic [7:0] OptServer = 8'd54;
    localparam logic [7:0] OptEnd    = 8'hFF;

    // Message type values
    localparam logic [7:0] MsgOffer = 8'd2;
    localparam logic [7:0] MsgAck   = 8'd5;
    localparam logic [7:0] MsgNak   = 8'd6;

    localparam logic [7:0] AddrLen = 8'd4;

    // Result tdata: fields packed low to high, padded to whole bytes
    localparam int ResultBits = 2 + 2 + WordW + WordW + 1 + WordW;
    localparam int ResultW    = ((ResultBits + 7) / 8) * 8;

    typedef struct packed {
        logic [WordW-1:0] lease_seconds;
        logic             server_seen;
        logic [WordW-1:0] server_address;
        logic [WordW-1:0] subnet_mask;
        logic [1:0]       lease_state;
        logic [1:0]       status;
    } result_t;

    function automatic logic [DataW-1:0] cookie_byte(input logic [1:0] idx);
        logic [DataW-1:0] b;
        case (idx)
            2'd0:    b = 8'h63;
            2'd1:    b = 8'h82;
            2'd2:    b = 8'h53;
            default: b = 8'h63;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[src/dop_parse_core.sv]
// Parser state and per-byte update logic for the DHCP options-area parser.
// Depends on dop_pkg; fed from the top level's input register.
`default_nettype none

module dop_parse_core
    import dop_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic [DataW-1:0] data_byte,
    input  wire logic             first,
    input  wire logic             last,
    output logic                  emit,
    output result_t               result
);

    logic [2:0]       phase_reg, phase_next;
    logic [1:0]       magic_reg, magic_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       left_reg, left_next;
    logic [2:0]       didx_reg, didx_next;
    logic [WordW-1:0] gather_reg, gather_next;
    logic [WordW-1:0] lease_reg, lease_next;
    logic             sflag_reg, sflag_next;
    logic [1:0]       mstate_reg, mstate_next;
    logic [WordW-1:0] subnet_reg, subnet_next;
    logic [WordW-1:0] server_reg, server_next;

    logic             fin;
    logic [1:0]       status;
    logic [7:0]       left_dec;
    logic [WordW-1:0] gather_byte;

    always_comb begin
        phase_next  = phase_reg;
        magic_next  = magic_reg;
        code_next   = code_reg;
        left_next   = left_reg;
        didx_next   = didx_reg;
        gather_next = gather_reg;
        lease_next  = lease_reg;
        sflag_next  = sflag_reg;
        mstate_next = mstate_reg;
        subnet_next = subnet_reg;
        server_next = server_reg;
        emit        = 1'b0;
        status      = StatusEnd;
        fin         = 1'b0;
        left_dec    = left_reg - 8'd1;
        gather_byte = '0;

        if (first) begin
            phase_next = PhMagic;
            magic_next = '0;
            lease_next = '0;
            sflag_next = 1'b0;
        end

        unique case (phase_next)
            PhMagic: begin
                if (data_byte != cookie_byte(magic_next)) begin
                    emit   = 1'b1;
                    status = StatusBadMagic;
                end else if (magic_next == 2'd3) begin
                    phase_next = PhCode;
                end else begin
                    magic_next = magic_next + 2'd1;
                end
            end
            PhCode: begin
                if (data_byte == OptEnd) begin
                    emit   = 1'b1;
                    status = StatusEnd;
                end else if (data_byte != OptPad) begin
                    code_next  = data_byte;
                    phase_next = PhLen;
                end
            end
            PhLen: begin
                left_next   = data_byte;
                didx_next   = '0;
                gather_next = '0;
                if ((code_reg == OptSubnet || code_reg == OptServer) && data_byte != AddrLen)
                    code_next = OptPad;
                if (data_byte == 8'd0)
                    fin = 1'b1;
                else
                    phase_next = PhData;
            end
            PhData: begin
                if (code_reg == OptType && didx_reg == 3'd0) begin
                    case (data_byte)
                        MsgOffer: mstate_next = LeaseOffer;
                        MsgAck:   mstate_next = LeaseAck;
                        MsgNak:   mstate_next = LeaseNak;
                        default:  mstate_next = mstate_reg;
                    endcase
                end
                if (!didx_reg[2]) begin
                    case (didx_reg[1:0])
                        2'd0:    gather_byte = {data_byte, 24'd0};
                        2'd1:    gather_byte = {8'd0, data_byte, 16'd0};
                        2'd2:    gather_byte = {16'd0, data_byte, 8'd0};
                        default: gather_byte = {24'd0, data_byte};
                    endcase
                    gather_next = gather_reg | gather_byte;
                    didx_next   = didx_reg + 3'd1;
                end
                left_next = left_dec;
                if (left_dec == 8'd0)
                    fin = 1'b1;
            end
            default: ;
        endcase

        // Apply the finished option record
        if (fin) begin
            if (code_next == OptSubnet) begin
                subnet_next = gather_next;
            end else if (code_next == OptServer) begin
                server_next = gather_next;
                sflag_next  = 1'b1;
            end else if (code_next == OptLease) begin
                lease_next = gather_next;
            end
            phase_next = PhCode;
        end

        if (!emit && last && phase_next != PhIdle && (first || phase_reg != PhIdle)) begin
            emit   = 1'b1;
            status = StatusNoEnd;
        end

        if (emit)
            phase_next = PhIdle;

        result.status         = status;
        result.lease_state    = mstate_next;
        result.subnet_mask    = subnet_next;
        result.server_address = server_next;
        result.server_seen    = sflag_next;
        result.lease_seconds  = lease_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PhIdle;
            magic_reg  <= '0;
            code_reg   <= '0;
            left_reg   <= '0;
            didx_reg   <= '0;
            gather_reg <= '0;
            lease_reg  <= '0;
            sflag_reg  <= 1'b0;
            mstate_reg <= LeaseNone;
            subnet_reg <= '0;
            server_reg <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            magic_reg  <= magic_next;
            code_reg   <= code_next;
            left_reg   <= left_next;
            didx_reg   <= didx_next;
            gather_reg <= gather_next;
            lease_reg  <= lease_next;
            sflag_reg  <= sflag_next;
            mstate_reg <= mstate_next;
            subnet_reg <= subnet_next;
            server_reg <= server_next;
        end
    end

endmodule

`default_nettype wire

[src/dop_out_reg.sv]
// Result register of the DHCP options-area parser: holds one result until taken.
// Depends on dop_pkg for the result layout.
`default_nettype none

module dop_out_reg
    import dop_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t load_data,
    output logic         out_free,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output result_t      m_result
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free)
            valid_next = load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the payload while the receiver stalls
    always_ff @(posedge aclk) begin
        if (out_free && load)
            data_reg <= load_data;
    end

    assign m_tvalid = valid_reg;
    assign m_result = data_reg;

endmodule

`default_nettype wire

[src/dhcp_option_parser.sv]
// Top level of the DHCP options-area parser: input register, parser core, result register.
// Depends on dop_pkg, dop_parse_core and dop_out_reg.
//
// Usage:
//   s_ channel: one byte of a DHCP options area per request, magic cookie first.
//     s_tdata carries the byte, s_tuser marks the first byte of a message,
//     s_tlast marks the final byte of the area.
//   m_ channel: one result per message, given at the end token, at a bad magic
//     cookie, or at the last byte when no end token came. m_tdata carries
//     status, lease state, subnet mask, server address, server flag, lease time.
//   Path: an accepted byte waits in the input register and is parsed into the
//     result register once that register is free; m_tvalid is registered there.
//   Throughput: one byte per cycle while no result is stalled on the m_ channel;
//     the per-byte update is a single pass of logic between the input register
//     and the parser state.
//   Reset (aresetn low, synchronous): clears the parser state, kept lease
//     state, subnet and server registers, and both valid flags.
//   Stall: while m_tready is low and a result waits, the parser stops; the
//     input register still takes one byte if it is empty, then s_tready drops.
`default_nettype none

module dhcp_option_parser
    import dop_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [DataW-1:0]   s_tdata,   // [7:0] data_byte
    input  wire logic               s_tuser,   // [0] first
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [ResultW-1:0]      m_tdata    // [1:0] status, [3:2] lease_state,
                                               // [35:4] subnet_mask, [67:36] server_address,
                                               // [68] server_seen, [100:69] lease_seconds
);

    logic             in_valid_reg, in_valid_next;
    logic [DataW-1:0] in_byte_reg;
    logic             in_first_reg;
    logic             in_last_reg;
    logic             out_free;
    logic             advance;
    logic             emit;
    result_t          core_result;
    result_t          m_result;

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    dop_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .first     (in_first_reg),
        .last      (in_last_reg),
        .emit      (emit),
        .result    (core_result)
    );

    dop_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && emit),
        .load_data (core_result),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata = {{(ResultW - ResultBits){1'b0}}, m_result};

endmodule

`default_nettype wire

[src/dhcp_option_parser_checker.sv]
// Port-level checks for the DHCP options-area parser, bound to the top level.
// Depends on dop_pkg for field layout and status codes.
`default_nettype none

module dhcp_option_parser_checker
    import dop_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [ResultW-1:0] m_tdata
);

    result_t res;
    assign res = m_tdata[ResultBits-1:0];

    // Stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input side only backs up behind a stalled result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request refused without a stalled result");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.status == StatusEnd || res.status == StatusBadMagic
                      || res.status == StatusNoEnd))
        else $error("illegal status code");

    // A bad cookie ends the message before any option was parsed
    a_badmagic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == StatusBadMagic |->
            !res.server_seen && res.lease_seconds == '0)
        else $error("bad cookie result carries per-message option data");

endmodule

bind dhcp_option_parser dhcp_option_parser_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[verif/tb_dhcp_option_parser.sv]
// Testbench for dhcp_option_parser: random and directed DHCP option areas on the s_ stream,
// every result on the m_ stream checked against a local model of the option walker.
// Depends on dop_pkg and the parser RTL.
`timescale 1ns / 100ps

import dop_pkg::*;

localparam logic [31:0] CookieWord = 32'h63825363;

function automatic logic [7:0] cookie_at(input int k);
    return CookieWord[31 - 8 * k -: 8];
endfunction

typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
} opt_byte_t;

// Tracks the parser state per request and holds the results it must produce.
class lease_scoreboard;
    logic [2:0]  phase;
    logic [1:0]  magic_idx;
    logic [7:0]  opt_code;
    logic [7:0]  bytes_left;
    logic [2:0]  data_idx;
    logic [31:0] gather;
    logic [31:0] lease_word;
    logic        server_flag;
    logic [1:0]  lease_state;
    logic [31:0] subnet_reg;
    logic [31:0] server_reg;
    result_t     expected_q[$];
    int          failures;

    function new();
        phase       = PhIdle;
        magic_idx   = '0;
        opt_code    = OptPad;
        bytes_left  = '0;
        data_idx    = '0;
        gather      = '0;
        lease_word  = '0;
        server_flag = 1'b0;
        lease_state = LeaseNone;
        subnet_reg  = '0;
        server_reg  = '0;
        failures    = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void close_option();
        if (opt_code == OptSubnet) begin
            subnet_reg = gather;
        end else if (opt_code == OptServer) begin
            server_reg  = gather;
            server_flag = 1'b1;
        end else if (opt_code == OptLease) begin
            lease_word = gather;
        end
        phase = PhCode;
    endfunction

    function void push_result(logic [1:0] status);
        result_t r;
        r.status         = status;
        r.lease_state    = lease_state;
        r.subnet_mask    = subnet_reg;
        r.server_address = server_reg;
        r.server_seen    = server_flag;
        r.lease_seconds  = lease_word;
        expected_q.push_back(r);
        phase = PhIdle;
    endfunction

    function void note_request(logic [7:0] b, logic first, logic last);
        int shift;
        if (first) begin
            phase       = PhMagic;
            magic_idx   = '0;
            lease_word  = '0;
            server_flag = 1'b0;
        end
        case (phase)
            PhMagic: begin
                if (b != cookie_at(int'(magic_idx))) begin
                    push_result(StatusBadMagic);
                    return;
                end
                if (magic_idx == 2'd3) phase = PhCode;
                else magic_idx = magic_idx + 2'd1;
            end
            PhCode: begin
                if (b == OptEnd) begin
                    push_result(StatusEnd);
                    return;
                end
                if (b != OptPad) begin
                    opt_code = b;
                    phase    = PhLen;
                end
            end
            PhLen: begin
                bytes_left = b;
                data_idx   = '0;
                gather     = '0;
                // address options only count with exactly four bytes
                if ((opt_code == OptSubnet || opt_code == OptServer) && b != AddrLen)
                    opt_code = OptPad;
                if (b == 8'd0) close_option();
                else phase = PhData;
            end
            PhData: begin
                if (opt_code == OptType && data_idx == 3'd0) begin
                    case (b)
                        MsgOffer: lease_state = LeaseOffer;
                        MsgAck:   lease_state = LeaseAck;
                        MsgNak:   lease_state = LeaseNak;
                        default:  ;
                    endcase
                end
                if (data_idx < 3'd4) begin
                    shift    = 24 - 8 * int'(data_idx);
                    gather   = gather | ({24'd0, b} << shift);
                    data_idx = data_idx + 3'd1;
                end
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) close_option();
            end
            default: return;
        endcase
        if (last) push_result(StatusNoEnd);
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: status=%0d state=%0d mask=%h server=%h seen=%0d lease=%h",
                         got.status, got.lease_state, got.subnet_mask, got.server_address,
                         got.server_seen, got.lease_seconds);
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status || got.lease_state !== want.lease_state ||
            got.subnet_mask !== want.subnet_mask || got.server_address !== want.server_address ||
            got.server_seen !== want.server_seen || got.lease_seconds !== want.lease_seconds) begin
            failures++;
            if (failures <= 10) begin
                $display("mismatch at %0t", $realtime);
                $display("  expected status=%0d state=%0d mask=%h server=%h seen=%0d lease=%h",
                         want.status, want.lease_state, want.subnet_mask, want.server_address,
                         want.server_seen, want.lease_seconds);
                $display("  actual   status=%0d state=%0d mask=%h server=%h seen=%0d lease=%h",
                         got.status, got.lease_state, got.subnet_mask, got.server_address,
                         got.server_seen, got.lease_seconds);
            end
        end
    endfunction
endclass

module tb_dhcp_option_parser;

    localparam int QuietLimit = 2000;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [DataW-1:0]   s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               s_tlast  = 1'b0;
    logic               m_tready = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [ResultW-1:0] m_tdata;

    lease_scoreboard sb = new();
    opt_byte_t       frame_q[$];
    int              idle_pct   = 0;
    int              stall_pct  = 0;
    int              live_bytes = 0;
    int              quiet      = 0;

    dhcp_option_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Check results before noting the request of the same edge; watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(result_t'(m_tdata[ResultBits-1:0]));
            if (s_tvalid && s_tready) sb.note_request(s_tdata, s_tuser, s_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet = 0;
            else quiet++;
            if (quiet >= QuietLimit) begin
                $display("timeout: no request or result for %0d cycles", QuietLimit);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic f, input logic l);
        opt_byte_t item;
        item.data  = b;
        item.first = f;
        item.last  = l;
        frame_q.push_back(item);
    endtask

    task automatic push_cookie();
        for (int k = 0; k < 4; k++) push_byte(cookie_at(k), k == 0, 1'b0);
    endtask

    task automatic push_option();
        int         sel;
        int         len;
        logic [7:0] code;
        logic [7:0] tv;
        sel = $urandom_range(99);
        if (sel < 10) begin
            repeat ($urandom_range(1, 3)) push_byte(OptPad, 1'b0, 1'b0);
            return;
        end
        if (sel < 25) begin
            code = OptType;
            len  = $urandom_range(99);
            len  = (len < 10) ? 0 : (len < 80) ? 1 : 2;
        end else if (sel < 55) begin
            code = (sel < 40) ? OptSubnet : OptServer;
            len  = ($urandom_range(99) < 85) ? 4 : $urandom_range(0, 6);
        end else if (sel < 70) begin
            code = OptLease;
            len  = ($urandom_range(99) < 60) ? 4 : $urandom_range(0, 7);
        end else begin
            code = 8'($urandom_range(1, 254));
            len  = ($urandom_range(99) < 3) ? $urandom_range(0, 255) : $urandom_range(0, 5);
        end
        push_byte(code, 1'b0, 1'b0);
        push_byte(8'(len), 1'b0, 1'b0);
        for (int i = 0; i < len; i++) begin
            if (code == OptType && i == 0) begin
                case ($urandom_range(3))
                    0:       tv = MsgOffer;
                    1:       tv = MsgAck;
                    2:       tv = MsgNak;
                    default: tv = 8'($urandom_range(255));
                endcase
                push_byte(tv, 1'b0, 1'b0);
            end else begin
                push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            end
        end
    endtask

    // Mostly well-formed areas; some cut short, some with a bad cookie, some restarted.
    task automatic build_frame();
        int         kind;
        int         start;
        int         pos;
        int         k;
        logic [7:0] wrong;
        // stray bytes between messages are dropped by the parser
        if ($urandom_range(99) < 6)
            repeat ($urandom_range(1, 3))
                push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        kind  = $urandom_range(99);
        start = frame_q.size();
        if (kind < 10) begin
            k = $urandom_range(3);
            for (int i = 0; i < k; i++) push_byte(cookie_at(i), i == 0, 1'b0);
            do wrong = 8'($urandom_range(255)); while (wrong == cookie_at(k));
            push_byte(wrong, k == 0, 1'($urandom_range(1)));
            live_bytes += frame_q.size() - start;
            repeat ($urandom_range(0, 3))
                push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        end else begin
            push_cookie();
            repeat ($urandom_range(0, 6)) push_option();
            if (kind < 70) begin
                push_byte(OptEnd, 1'b0, 1'($urandom_range(1)));
                live_bytes += frame_q.size() - start;
                if (!frame_q[frame_q.size() - 1].last) begin
                    repeat ($urandom_range(0, 2)) push_byte(OptPad, 1'b0, 1'b0);
                    push_byte(OptPad, 1'b0, 1'b1);
                end
            end else begin
                pos = $urandom_range(start, frame_q.size() - 1);
                while (frame_q.size() > pos + 1) void'(frame_q.pop_back());
                if (kind < 85) begin
                    frame_q[pos].last = 1'b1;
                end else begin
                    push_cookie();
                    repeat ($urandom_range(0, 6)) push_option();
                    push_byte(OptEnd, 1'b0, 1'($urandom_range(1)));
                end
                live_bytes += frame_q.size() - start;
            end
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) begin
            s_tdata  <= frame_q[i].data;
            s_tuser  <= frame_q[i].first;
            s_tlast  <= frame_q[i].last;
            s_tvalid <= 1'b1;
            do @(posedge aclk); while (!s_tready);
            @(negedge aclk);
            while ($urandom_range(99) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        frame_q.delete();
    endtask

    // Hold off the sender until every pending result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // full message: offer, subnet with extreme bytes, end token
        push_cookie();
        push_byte(OptType, 1'b0, 1'b0);
        push_byte(8'd1, 1'b0, 1'b0);
        push_byte(MsgOffer, 1'b0, 1'b0);
        push_byte(OptSubnet, 1'b0, 1'b0);
        push_byte(AddrLen, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(OptEnd, 1'b0, 1'b0);
        // bad cookie on the first byte, then a stray byte that is dropped
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h55, 1'b0, 1'b1);
        // server identifier, short lease cut by the last byte
        push_cookie();
        push_byte(OptServer, 1'b0, 1'b0);
        push_byte(AddrLen, 1'b0, 1'b0);
        push_byte(8'h0A, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(OptLease, 1'b0, 1'b0);
        push_byte(8'd2, 1'b0, 1'b0);
        push_byte(8'hAB, 1'b0, 1'b0);
        push_byte(8'hCD, 1'b0, 1'b1);
        send_frame();
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 84; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            live_bytes = 0;
            while (live_bytes < 125) begin
                build_frame();
                send_frame();
                if ($urandom_range(99) < 5) drain_results();
            end
            drain_results();
        end

        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
